// File: rtl/base64_line_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// base64_line_receiver_unit_assert
// Assertion macros shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef BASE64_LINE_RECEIVER_UNIT_ASSERT_SVH
`define BASE64_LINE_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define B64LR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64LR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/b64lr_pkg.sv
// ----------------------------------------------------------------------------
// b64lr_pkg
// Shared types, codes and the base64 letter decode for the line receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package b64lr_pkg;

    localparam int RES_CNT_W = 6;
    localparam int MAX_RESULTS = 60;

    localparam logic [19:0] TIMEOUT_RESET = 20'd30000;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [7:0] VAL_LOWER_BASE = 8'd26;
    localparam logic [7:0] VAL_DIGIT_BASE = 8'd52;
    localparam logic [5:0] VAL_PLUS       = 6'd62;
    localparam logic [5:0] VAL_SLASH      = 6'd63;

    typedef enum logic [1:0] {
        STATUS_BYTE     = 2'd0,
        STATUS_END      = 2'd1,
        STATUS_TIMEOUT  = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PROC,
        ST_FLUSH
    } state_t;

    // Per-character answer of the unpack unit.
    typedef struct packed {
        logic       is_letter;
        logic       is_pad;
        logic       byte_ok;
        logic [7:0] data;
    } unpack_t;

    // Returns {valid, value}; valid is low for anything but a base64 letter.
    function automatic logic [6:0] letter_value(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            r = {1'b1, 6'(c - 8'h61 + VAL_LOWER_BASE)};
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, 6'(c - 8'h30 + VAL_DIGIT_BASE)};
        end
        else if (c == CHAR_PLUS)
        begin
            r = {1'b1, VAL_PLUS};
        end
        else if (c == CHAR_SLASH)
        begin
            r = {1'b1, VAL_SLASH};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/b64lr_line_mem.sv
// ----------------------------------------------------------------------------
// b64lr_line_mem
// Line buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module b64lr_line_mem #(
    parameter int DEPTH = 80,
    parameter int AW    = 7
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64lr_unpack.sv
// ----------------------------------------------------------------------------
// b64lr_unpack
// Shared 6-to-8 bit repacker: takes one letter per step, gives a byte on
// every letter but the first of a group of four.
// ----------------------------------------------------------------------------
`default_nettype none

module b64lr_unpack
    import b64lr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       clear,
    input  wire logic       advance,
    input  wire logic [7:0] char_code,
    output unpack_t         result
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [5:0] prev_reg;
    logic [5:0] prev_next;
    logic [6:0] lv;
    logic [5:0] v;

    always_comb
    begin
        lv = letter_value(char_code);
        v  = lv[5:0];
        result.is_letter = lv[6];
        result.is_pad    = (char_code == CHAR_PAD);
        result.byte_ok   = lv[6] && (phase_reg != 2'd0);
        case (phase_reg)
            2'd1:    result.data = {prev_reg, v[5:4]};
            2'd2:    result.data = {prev_reg[3:0], v[5:2]};
            2'd3:    result.data = {prev_reg[1:0], v};
            default: result.data = 8'd0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        if (clear)
        begin
            phase_next = 2'd0;
        end
        else if (advance && lv[6])
        begin
            phase_next = 2'(phase_reg + 2'd1);
            prev_next  = v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
    end

endmodule

`default_nettype wire

// File: rtl/base64_line_receiver_unit.sv
// A timeout, end-of-transfer or overflow result is parked in the holding slot
//   when its transaction is taken, then moved to the output register in the flush state.
// Decoding a stored line: each character is read from the line buffer, then
//   stepped through the shared unpack unit; a flush state ends the walk.
// No new transaction is taken while a line is decoded; output stalls hold the walk.
// Reset (rst_n, async, active low) clears line state, counters and the session.
// ----------------------------------------------------------------------------
// base64_line_receiver_unit
// Line-oriented base64 receiver: buffers characters up to LF, then walks the
// line through a shared unpack unit and streams out the decoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_line_receiver_unit_assert.svh"

module base64_line_receiver_unit
    import b64lr_pkg::*;
#(
    parameter int MAX_LINE_CHARS = 80
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] kind (0 character, 1 tick)
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [7:0] data_byte, [31:8] byte_total
    output logic      [1:0]  m_tuser,   // [1:0] status
    output logic             m_tlast,
    // configuration: idle timeout limit in ticks
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [19:0] cfg_data
);

    localparam int AW    = $clog2(MAX_LINE_CHARS);
    localparam int LEN_W = $clog2(MAX_LINE_CHARS + 1);
    localparam logic [LEN_W-1:0] LINE_MAX = LEN_W'(MAX_LINE_CHARS);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic                 session_over_reg, session_over_next;
    logic [19:0]          timeout_reg, timeout_next;
    logic [19:0]          idle_reg, idle_next;
    logic [23:0]          total_reg, total_next;
    logic [LEN_W-1:0]     line_len_reg, line_len_next;
    logic                 all_b64_reg, all_b64_next;
    logic                 ovf_reg, ovf_next;
    logic [7:0]           first_char_reg, first_char_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    // Holding slot: the newest result waits here until we know if it is last.
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_byte_reg, pend_byte_next;
    status_t              pend_status_reg, pend_status_next;
    logic [23:0]          pend_total_reg, pend_total_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    status_t              out_status_reg, out_status_next;
    logic [23:0]          out_total_reg, out_total_next;
    logic                 out_last_reg, out_last_next;

    // ------------------------------------------------------------------
    // Decode of the incoming transaction
    // ------------------------------------------------------------------
    logic        in_acc;
    logic        live;
    logic        is_tick;
    logic        is_char;
    logic        is_cr;
    logic        is_lf;
    logic [6:0]  in_lv;
    logic [19:0] idle_inc;
    logic [23:0] total_inc;
    logic        timed_out;
    logic        dot_line;
    logic        walk_line;
    logic        line_room;

    assign in_acc    = s_tvalid && s_tready;
    assign live      = in_acc && !session_over_reg;
    assign is_tick   = live && s_tuser;
    assign is_char   = live && !s_tuser;
    assign is_cr     = s_tdata == CHAR_CR;
    assign is_lf     = s_tdata == CHAR_LF;
    assign in_lv     = letter_value(s_tdata);
    assign idle_inc  = (idle_reg == 20'hFFFFF) ? idle_reg : idle_reg + 20'd1;
    assign total_inc = (total_reg == 24'hFFFFFF) ? total_reg : total_reg + 24'd1;
    assign timed_out = idle_inc > timeout_reg;
    assign dot_line  = (line_len_reg == LEN_W'(1)) && (first_char_reg == CHAR_DOT);
    assign walk_line = !ovf_reg && !dot_line && (line_len_reg != '0) && all_b64_reg;
    assign line_room = line_len_reg < LINE_MAX;

    // ------------------------------------------------------------------
    // Line buffer and shared unpack unit
    // ------------------------------------------------------------------
    logic       mem_wr_en;
    logic       mem_rd_en;
    logic [7:0] mem_rd_data;
    logic       unit_clear;
    logic       unit_advance;
    unpack_t    unit_res;

    assign mem_wr_en = is_char && !is_cr && !is_lf && line_room;

    b64lr_line_mem #(
        .DEPTH (MAX_LINE_CHARS),
        .AW    (AW)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (line_len_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    b64lr_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (unit_clear),
        .advance   (unit_advance),
        .char_code (mem_rd_data),
        .result    (unit_res)
    );

    // A byte goes out only below the per-line result cap.
    logic out_free;
    logic emit;
    logic proc_go;
    logic walk_last;

    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = unit_res.byte_ok && (res_cnt_reg < RES_CNT_W'(MAX_RESULTS));
    assign proc_go   = (state_reg == ST_PROC)
                       && (unit_res.is_pad || !emit || !pend_valid_reg || out_free);
    assign walk_last = (LEN_W'(idx_reg) + LEN_W'(1)) == line_len_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_tick && timed_out)
                begin
                    state_next = ST_FLUSH;
                end
                else if (is_char && is_lf)
                begin
                    if (ovf_reg || dot_line)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (walk_line)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_PROC;
            end
            ST_PROC:
            begin
                // Stop the walk at the first pad character.
                if (unit_res.is_pad)
                begin
                    state_next = ST_FLUSH;
                end
                else if (proc_go)
                begin
                    state_next = walk_last ? ST_FLUSH : ST_FETCH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready     = 1'b0;
        mem_rd_en    = 1'b0;
        unit_clear   = 1'b0;
        unit_advance = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                unit_clear = 1'b1;
            end
            ST_FETCH:
            begin
                mem_rd_en = 1'b1;
            end
            ST_PROC:
            begin
                unit_advance = proc_go && !unit_res.is_pad;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Datapath updates
    // ------------------------------------------------------------------
    logic push_mid;
    logic push_end;
    logic take_byte;

    assign take_byte = unit_advance && emit;
    assign push_mid  = take_byte && pend_valid_reg;
    assign push_end  = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;

    always_comb
    begin
        session_over_next = session_over_reg;
        timeout_next      = timeout_reg;
        idle_next         = idle_reg;
        total_next        = total_reg;
        line_len_next     = line_len_reg;
        all_b64_next      = all_b64_reg;
        ovf_next          = ovf_reg;
        first_char_next   = first_char_reg;
        idx_next          = idx_reg;
        res_cnt_next      = res_cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_byte_next    = pend_byte_reg;
        pend_status_next  = pend_status_reg;
        pend_total_next   = pend_total_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_byte_next     = out_byte_reg;
        out_status_next   = out_status_reg;
        out_total_next    = out_total_reg;
        out_last_next     = out_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            timeout_next = cfg_data;
        end

        // Tick: count idle time, report a timeout once and end the session.
        if (is_tick)
        begin
            idle_next = idle_inc;
            if (timed_out)
            begin
                pend_valid_next   = 1'b1;
                pend_byte_next    = 8'd0;
                pend_status_next  = STATUS_TIMEOUT;
                pend_total_next   = total_reg;
                session_over_next = 1'b1;
            end
        end

        // Character: any character clears the idle count; CR is dropped.
        if (is_char)
        begin
            idle_next = 20'd0;
            if (is_lf)
            begin
                if (ovf_reg)
                begin
                    pend_valid_next  = 1'b1;
                    pend_byte_next   = 8'd0;
                    pend_status_next = STATUS_OVERFLOW;
                    pend_total_next  = total_reg;
                end
                else if (dot_line)
                begin
                    pend_valid_next   = 1'b1;
                    pend_byte_next    = 8'd0;
                    pend_status_next  = STATUS_END;
                    pend_total_next   = total_reg;
                    session_over_next = 1'b1;
                end
                if (walk_line)
                begin
                    idx_next     = '0;
                    res_cnt_next = '0;
                end
                else
                begin
                    line_len_next = '0;
                    all_b64_next  = 1'b1;
                    ovf_next      = 1'b0;
                end
            end
            else if (!is_cr)
            begin
                if (!in_lv[6] && (s_tdata != CHAR_PAD))
                begin
                    all_b64_next = 1'b0;
                end
                if (line_room)
                begin
                    line_len_next = line_len_reg + LEN_W'(1);
                    if (line_len_reg == '0)
                    begin
                        first_char_next = s_tdata;
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end

        // Walk step: advance the read index, park each new byte in the slot.
        if (unit_advance)
        begin
            idx_next = AW'(idx_reg + AW'(1));
        end
        if (push_mid)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_status_next = pend_status_reg;
            out_total_next  = pend_total_reg;
            out_last_next   = 1'b0;
        end
        if (take_byte)
        begin
            total_next       = total_inc;
            res_cnt_next     = res_cnt_reg + RES_CNT_W'(1);
            pend_valid_next  = 1'b1;
            pend_byte_next   = unit_res.data;
            pend_status_next = STATUS_BYTE;
            pend_total_next  = total_inc;
        end

        // Flush: the parked result is the last one of this transaction.
        if (push_end)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_status_next = pend_status_reg;
            out_total_next  = pend_total_reg;
            out_last_next   = 1'b1;
        end
        if ((state_reg == ST_FLUSH) && (state_next == ST_IDLE))
        begin
            line_len_next = '0;
            all_b64_next  = 1'b1;
            ovf_next      = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            session_over_reg <= 1'b0;
            timeout_reg      <= TIMEOUT_RESET;
            idle_reg         <= 20'd0;
            total_reg        <= 24'd0;
            line_len_reg     <= '0;
            all_b64_reg      <= 1'b1;
            ovf_reg          <= 1'b0;
            idx_reg          <= '0;
            res_cnt_reg      <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            session_over_reg <= session_over_next;
            timeout_reg      <= timeout_next;
            idle_reg         <= idle_next;
            total_reg        <= total_next;
            line_len_reg     <= line_len_next;
            all_b64_reg      <= all_b64_next;
            ovf_reg          <= ovf_next;
            idx_reg          <= idx_next;
            res_cnt_reg      <= res_cnt_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload: no reset needed, qualified by the valid flags.
    always_ff @(posedge clk)
    begin
        first_char_reg  <= first_char_next;
        pend_byte_reg   <= pend_byte_next;
        pend_status_reg <= pend_status_next;
        pend_total_reg  <= pend_total_next;
        out_byte_reg    <= out_byte_next;
        out_status_reg  <= out_status_next;
        out_total_reg   <= out_total_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_total_reg, out_byte_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `B64LR_ASSERT_IMP(a_idle_slot_empty, clk, rst_n,
        state_reg == ST_IDLE, !pend_valid_reg,
        "holding slot occupied while idle")
    `B64LR_ASSERT_IMP(a_status_byte_zero, clk, rst_n,
        out_valid_reg && (out_status_reg != STATUS_BYTE), out_byte_reg == 8'd0,
        "non-byte result carries a nonzero data byte")
    `B64LR_ASSERT_NXT(a_over_ignored, clk, rst_n,
        in_acc && session_over_reg, (state_reg == ST_IDLE) && !pend_valid_reg,
        "transaction after session end produced work")

endmodule

`default_nettype wire

// File: sim/base64_line_receiver_unit_tb.sv
// ----------------------------------------------------------------------------
// base64_line_receiver_unit_tb
// Streams characters and idle ticks into the line receiver with random
// gaps and output stalls. A mirror of the receiver, kept inside the bench,
// predicts every decoded byte, end, timeout and overflow report. Each result
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module base64_line_receiver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64lr_pkg::*;

    localparam int LINE_CHARS    = 80;
    localparam int SETTLE_CYCLES = 2 * LINE_CHARS + 40;
    localparam int RUN_LIMIT     = 4000000;
    localparam int LONG_HOLD     = 600;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [19:0] IDLE_SAT  = 20'hFFFFF;
    localparam logic [23:0] TOTAL_SAT = 24'hFFFFFF;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } serial_item_t;

    typedef struct packed {
        logic [7:0]  data;
        status_t     status;
        logic [23:0] total;
        logic        last;
    } rx_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] char_code
    logic        s_tuser   = 1'b0;  // [0] kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // [7:0] data_byte, [31:8] byte_total
    logic [1:0]  m_tuser;           // [1:0] status
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [19:0] cfg_data  = '0;

    base64_line_receiver_unit #(
        .MAX_LINE_CHARS(LINE_CHARS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Mirror of the receiver: line buffer, counters, session flag, timeout.
    // ------------------------------------------------------------------------
    logic [7:0]  line_buf [LINE_CHARS];
    int          line_len    = 0;
    bit          line_b64    = 1'b1;
    bit          line_ovf    = 1'b0;
    bit          rx_done     = 1'b0;
    logic [19:0] idle_cnt    = '0;
    logic [19:0] timeout_reg = TIMEOUT_RESET;
    logic [23:0] total_cnt   = '0;

    rx_result_t   due_results [$];
    serial_item_t serial_feed [$];

    int  fail_cnt       = 0;
    int  send_gap       = 0;
    int  ready_hold     = 0;
    bit  no_gaps        = 1'b0;
    bit  long_hold_req  = 1'b0;
    bit  long_hold_done = 1'b0;

    // Stimulus-side bookkeeping: keeps the idle count within the timeout until the end.
    int  gen_idle    = 0;
    int  gen_timeout = int'(TIMEOUT_RESET);
    int  gen_count   = 0;

    // Return 1 and the 6-bit value for a base64 letter, 0 for anything else.
    function automatic bit sextet_of(input logic [7:0] c, output logic [5:0] v);
        v = 6'd0;
        if (c >= "A" && c <= "Z")
            v = 6'(c - "A");
        else if (c >= "a" && c <= "z")
            v = 6'(c - "a" + VAL_LOWER_BASE);
        else if (c >= "0" && c <= "9")
            v = 6'(c - "0" + VAL_DIGIT_BASE);
        else if (c == CHAR_PLUS)
            v = VAL_PLUS;
        else if (c == CHAR_SLASH)
            v = VAL_SLASH;
        else
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic rx_result_t report(input status_t st);
        rx_result_t r;
        r.data   = 8'd0;
        r.status = st;
        r.total  = total_cnt;
        r.last   = 1'b1;
        return r;
    endfunction

    // Walk the stored line: four letters give three bytes, stop at the first
    // pad, a trailing pair or triple gives one or two bytes.
    task automatic decode_stored_line();
        logic [5:0] quad [4];
        logic [5:0] v;
        logic [7:0] out_bytes [$];
        int         n;
        int         cnt;
        rx_result_t r;
        n = 0;
        for (int i = 0; i < line_len; i++)
        begin
            if (line_buf[i] == CHAR_PAD)
                break;
            if (!sextet_of(line_buf[i], v))
                continue;
            quad[n] = v;
            n++;
            if (n == 4)
            begin
                out_bytes.push_back({quad[0], quad[1][5:4]});
                out_bytes.push_back({quad[1][3:0], quad[2][5:2]});
                out_bytes.push_back({quad[2][1:0], quad[3]});
                n = 0;
            end
        end
        if (n >= 2)
            out_bytes.push_back({quad[0], quad[1][5:4]});
        if (n == 3)
            out_bytes.push_back({quad[1][3:0], quad[2][5:2]});
        cnt = (out_bytes.size() > MAX_RESULTS) ? MAX_RESULTS : out_bytes.size();
        for (int k = 0; k < cnt; k++)
        begin
            if (total_cnt != TOTAL_SAT)
                total_cnt++;
            r.data   = out_bytes[k];
            r.status = STATUS_BYTE;
            r.total  = total_cnt;
            r.last   = (k == cnt - 1);
            due_results.push_back(r);
        end
    endtask

    // Advance the mirror by one accepted input transaction.
    task automatic track_item(input logic kind, input logic [7:0] ch);
        logic [5:0] v;
        if (rx_done)
            return;
        if (kind == KIND_TICK)
        begin
            if (idle_cnt != IDLE_SAT)
                idle_cnt++;
            if (idle_cnt > timeout_reg)
            begin
                due_results.push_back(report(STATUS_TIMEOUT));
                rx_done = 1'b1;
            end
            return;
        end
        idle_cnt = '0;
        if (ch == CHAR_CR)
            return;
        if (ch == CHAR_LF)
        begin
            if (line_ovf)
                due_results.push_back(report(STATUS_OVERFLOW));
            else if (line_len == 1 && line_buf[0] == CHAR_DOT)
            begin
                due_results.push_back(report(STATUS_END));
                rx_done = 1'b1;
            end
            else if (line_len > 0 && line_b64)
                decode_stored_line();
            line_len = 0;
            line_b64 = 1'b1;
            line_ovf = 1'b0;
            return;
        end
        if (!sextet_of(ch, v) && ch != CHAR_PAD)
            line_b64 = 1'b0;
        if (line_len < LINE_CHARS)
        begin
            line_buf[line_len] = ch;
            line_len++;
        end
        else
            line_ovf = 1'b1;
    endtask

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and run limit.
    // ------------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("base64_line_receiver_unit_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: hold the current item until its transaction completes,
    // then feed the mirror and advance to the next queued item or a gap.
    // ------------------------------------------------------------------------
    serial_item_t feed_head;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= KIND_CHAR;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                track_item(s_tuser, s_tdata);
            if (send_gap != 0)
            begin
                s_tvalid <= 1'b0;
                send_gap--;
            end
            else if (serial_feed.size() != 0)
            begin
                feed_head = serial_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= feed_head.ch;
                s_tuser  <= feed_head.kind;
                send_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each completed transaction, then decide readiness.
    // One long hold, requested once, lets the block back up onto its input.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        rx_result_t want;
        int         n;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: data_byte %0h status %0d byte_total %0d",
                           m_tdata[7:0], m_tuser, m_tdata[31:8]);
                    fail_cnt++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tdata[7:0] !== want.data)
                    begin
                        $error("data_byte: expected %0h, got %0h", want.data, m_tdata[7:0]);
                        fail_cnt++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata[31:8] !== want.total)
                    begin
                        $error("byte_total: expected %0d, got %0d", want.total, m_tdata[31:8]);
                        fail_cnt++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        fail_cnt++;
                    end
                end
            end

            if (ready_hold != 0)
            begin
                m_tready <= 1'b0;
                ready_hold--;
            end
            else if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                ready_hold = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
            begin
                n = pick_gap();
                if (n == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    ready_hold = n - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_item(input logic kind, input logic [7:0] ch);
        serial_item_t it;
        it.kind = kind;
        it.ch   = ch;
        serial_feed.push_back(it);
        gen_count++;
        if (kind == KIND_TICK)
            gen_idle++;
        else
            gen_idle = 0;
    endtask

    task automatic push_char(input logic [7:0] ch);
        push_item(KIND_CHAR, ch);
    endtask

    // Add a tick only while the idle count stays within the timeout.
    task automatic maybe_tick(input int pct);
        if ($urandom_range(0, 99) < pct && gen_idle < gen_timeout)
            push_item(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    task automatic push_eol();
        if ($urandom_range(0, 2) == 0)
            push_char(CHAR_CR);
        push_char(CHAR_LF);
    endtask

    function automatic logic [7:0] rand_letter();
        int idx;
        idx = $urandom_range(0, 63);
        if (idx < 26)
            return 8'("A" + idx);
        if (idx < 52)
            return 8'("a" + idx - 26);
        if (idx < 62)
            return 8'("0" + idx - 52);
        return (idx == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // Any byte but LF and the dot, so that noise never forms an end line.
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CHAR_LF || c == CHAR_DOT);
        return c;
    endfunction

    task automatic push_b64_line();
        int letters;
        letters = 4 * $urandom_range(0, 4) + $urandom_range(0, 3);
        for (int i = 0; i < letters; i++)
        begin
            push_char(rand_letter());
            maybe_tick(8);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2)) push_char(CHAR_PAD);
            repeat ($urandom_range(0, 3)) push_char(rand_letter());
        end
        push_eol();
    endtask

    // A full line of letters, or one that runs past the buffer.
    task automatic push_long_line(input bit overflow);
        int len;
        len = overflow ? LINE_CHARS + $urandom_range(1, 8) : LINE_CHARS;
        for (int i = 0; i < len; i++)
            push_char((overflow && $urandom_range(0, 9) == 0) ? CHAR_PAD : rand_letter());
        push_char(CHAR_LF);
    endtask

    task automatic random_traffic(input int n);
        int stop;
        int pick;
        stop = gen_count + n;
        while (gen_count < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                push_b64_line();
            else if (pick < 65)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    push_char(noise_char());
                    maybe_tick(8);
                end
                push_eol();
            end
            else if (pick < 70)
                push_eol();
            else if (pick < 75)
            begin
                if ($urandom_range(0, 1) == 0)
                    repeat ($urandom_range(1, 3)) push_char(CHAR_PAD);
                else
                    push_char(rand_letter());
                push_eol();
            end
            else if (pick < 79)
            begin
                // two-character lines holding a dot: skipped, never an end
                if ($urandom_range(0, 1) == 0)
                begin
                    push_char(CHAR_DOT);
                    push_char(($urandom_range(0, 1) == 0) ? rand_letter() : CHAR_DOT);
                end
                else
                begin
                    push_char(($urandom_range(0, 1) == 0) ? rand_letter() : CHAR_PAD);
                    push_char(CHAR_DOT);
                end
                push_eol();
            end
            else if (pick < 93)
                repeat ($urandom_range(1, 3)) maybe_tick(100);
            else
                push_char(noise_char());
        end
    endtask

    // Hold until the feed is empty and every prediction has been seen, then
    // allow the block to finish any line walk that produces nothing.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (serial_feed.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [19:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        timeout_reg = v;
        gen_timeout = int'(v);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int t;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, padding, short tails, lone letter,
        // pad-only, empty and non-base64 lines, one tick.
        push_text("AA//");
        push_char(CHAR_CR);
        push_char(CHAR_LF);
        push_text("QQ==");
        push_char(CHAR_LF);
        push_text("+/9");
        push_char(CHAR_LF);
        push_text("Q");
        push_char(CHAR_LF);
        push_char(CHAR_PAD);
        push_char(CHAR_LF);
        push_char(CHAR_LF);
        push_text("A.");
        push_char(CHAR_LF);
        push_item(KIND_TICK, 8'hFF);
        wait_drained();

        // Tightest legal timeout: at most one tick between characters.
        set_timeout(20'd1);
        random_traffic(20);
        wait_drained();

        // Full-width register; no gaps, and the bench holds off reading results while an
        // overflowing line and a decoded line go in, so the input side backs up.
        set_timeout(IDLE_SAT);
        no_gaps = 1'b1;
        long_hold_req = 1'b1;
        push_long_line(1'b1);
        push_text("TWFuTWFu");
        push_char(CHAR_LF);
        random_traffic(15);
        wait_drained();
        no_gaps = 1'b0;

        set_timeout(20'd1000000);
        random_traffic(20);
        wait_drained();

        // Small timeout: run the idle count right up to it, then traffic.
        set_timeout(20'($urandom_range(2, 20)));
        push_char(rand_letter());
        while (gen_idle < gen_timeout)
            push_item(KIND_TICK, 8'($urandom_range(0, 255)));
        random_traffic(20);
        wait_drained();

        set_timeout(20'($urandom_range(1, int'(IDLE_SAT))));
        random_traffic(15);
        wait_drained();

        // Close the session one of three ways, then send items it must drop.
        case ($urandom_range(0, 2))
            0:
            begin
                push_char(CHAR_LF);
                push_char(CHAR_DOT);
                push_eol();
            end
            1:
            begin
                set_timeout(20'd0);
                push_item(KIND_TICK, 8'($urandom_range(0, 255)));
            end
            default:
            begin
                t = $urandom_range(1, 8);
                set_timeout(20'(t));
                push_char(rand_letter());
                repeat (t + 1) push_item(KIND_TICK, 8'($urandom_range(0, 255)));
            end
        endcase
        push_text("TWFu");
        push_char(CHAR_LF);
        repeat (3) push_item(KIND_TICK, 8'($urandom_range(0, 255)));
        push_char(CHAR_DOT);
        push_char(CHAR_LF);
        wait_drained();

        if (fail_cnt == 0)
            $display("base64_line_receiver_unit_tb OK");
        else
            $display("base64_line_receiver_unit_tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/b64lr_pkg.sv
rtl/b64lr_line_mem.sv
rtl/b64lr_unpack.sv
rtl/base64_line_receiver_unit.sv
sim/base64_line_receiver_unit_tb.sv
